/* hdl/sorted_list_with_pair_sum_count_top_macros.svh */
`ifndef SORTED_LIST_WITH_PAIR_SUM_COUNT_TOP_MACROS_SVH
`define SORTED_LIST_WITH_PAIR_SUM_COUNT_TOP_MACROS_SVH

// same-cycle implication, checked on clk, off during reset
`define SLPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define SLPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/slpc_pkg.sv */
package slpc_pkg;

    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 16;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int SUM_W       = VALUE_WIDTH + 1;

    localparam int ACTION_W   = 2;
    localparam int VALUE_IN_W = 16;
    localparam int STATUS_W   = 2;
    localparam int LEN_W      = 5;
    localparam int PAIR_W     = 7;
    localparam int LEN_MAX    = 31;
    localparam int PAIR_MAX   = 127;

    localparam int LEN_LSB      = STATUS_W;
    localparam int PAIR_LSB     = STATUS_W + LEN_W;
    localparam int OUT_FIELDS_W = STATUS_W + LEN_W + PAIR_W;
    localparam int S_TDATA_W    = ((VALUE_IN_W + 7) / 8) * 8;
    localparam int M_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_COUNT  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    typedef struct packed {
        logic                   shift_ins;
        logic                   shift_del;
        logic [IDX_W-1:0]       pos;
        logic [IDX_W-1:0]       rd_idx;
        logic [VALUE_WIDTH-1:0] wr_value;
    } store_ctl_t;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] x;
        logic [VALUE_WIDTH-1:0] y;
        logic [SUM_W-1:0]       cmp;
    } alu_req_t;

    typedef struct packed {
        logic lt;
        logic eq;
    } alu_rsp_t;

    function automatic logic [LEN_W-1:0] sat_len(input logic [CNT_W-1:0] n);
        if (32'(n) > LEN_MAX)
        begin
            return LEN_W'(LEN_MAX);
        end
        return LEN_W'(n);
    endfunction

endpackage

/* hdl/sorted_list_with_pair_sum_count_top.sv */
// channel   direction  fields (lowest bit up)
// s_*       in         tuser: action; tdata: value
// m_*       out        tdata: status, entry_count, pair_count
//
// insert and delete: a compare walk over the stored entries, then one shift unless the delete value is missing
// count: a pivot read per row, then one pair per cycle through the shared adder
// one word at a time: s_tready is high only while the sequencer is idle
// a finished result waits in the output register; the next word is taken meanwhile
// rst_n clears the length, the sequencer and the output valid; stored values are not cleared
module sorted_list_with_pair_sum_count_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [slpc_pkg::S_TDATA_W-1:0]   s_tdata,  // value
    input  logic [slpc_pkg::ACTION_W-1:0]    s_tuser,  // action
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [slpc_pkg::M_TDATA_W-1:0]   m_tdata   // status, entry_count, pair_count
);
    import slpc_pkg::*;

    store_ctl_t             ctl;
    alu_req_t               alu_req;
    alu_rsp_t               alu_rsp;
    status_t                status;
    logic [LEN_W-1:0]       entry_count;
    logic [PAIR_W-1:0]      pair_count;
    logic [VALUE_WIDTH-1:0] rd_data;
    logic [VALUE_WIDTH-1:0] in_value;

    assign in_value = VALUE_WIDTH'(s_tdata[VALUE_IN_W-1:0]);

    slpc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .action      (action_t'(s_tuser)),
        .value       (in_value),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .status      (status),
        .entry_count (entry_count),
        .pair_count  (pair_count),
        .ctl         (ctl),
        .rd_data     (rd_data),
        .alu_req     (alu_req),
        .alu_rsp     (alu_rsp)
    );

    slpc_store u_store (
        .clk     (clk),
        .ctl     (ctl),
        .rd_data (rd_data)
    );

    slpc_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign m_tdata = {{(M_TDATA_W - OUT_FIELDS_W){1'b0}}, pair_count, entry_count, status};

endmodule

/* hdl/slpc_alu.sv */
module slpc_alu (
    input  slpc_pkg::alu_req_t req,
    output slpc_pkg::alu_rsp_t rsp
);
    import slpc_pkg::*;

    logic [SUM_W-1:0] sum;

    assign sum    = {1'b0, req.x} + {1'b0, req.y};
    assign rsp.lt = (sum < req.cmp);
    assign rsp.eq = (sum == req.cmp);

endmodule

/* hdl/slpc_store.sv */
module slpc_store (
    input  logic                                 clk,
    input  slpc_pkg::store_ctl_t                 ctl,
    output logic [slpc_pkg::VALUE_WIDTH-1:0]     rd_data
);
    import slpc_pkg::*;

    logic [VALUE_WIDTH-1:0] ent_reg  [DEPTH];
    logic [VALUE_WIDTH-1:0] ent_next [DEPTH];

    // each cell sees only its two neighbors
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        localparam int KP = (k == 0) ? 0 : k - 1;
        localparam int KN = (k == DEPTH - 1) ? k : k + 1;

        always_comb
        begin
            ent_next[k] = ent_reg[k];
            if (ctl.shift_ins)
            begin
                if (IDX_W'(k) == ctl.pos)
                begin
                    ent_next[k] = ctl.wr_value;
                end
                else if (IDX_W'(k) > ctl.pos)
                begin
                    ent_next[k] = ent_reg[KP];
                end
            end
            else if (ctl.shift_del)
            begin
                if (IDX_W'(k) >= ctl.pos)
                begin
                    ent_next[k] = ent_reg[KN];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign rd_data = ent_reg[ctl.rd_idx];

endmodule

/* hdl/slpc_ctrl.sv */
module slpc_ctrl (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  slpc_pkg::action_t                  action,
    input  logic [slpc_pkg::VALUE_WIDTH-1:0]   value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output slpc_pkg::status_t                  status,
    output logic [slpc_pkg::LEN_W-1:0]         entry_count,
    output logic [slpc_pkg::PAIR_W-1:0]        pair_count,
    output slpc_pkg::store_ctl_t               ctl,
    input  logic [slpc_pkg::VALUE_WIDTH-1:0]   rd_data,
    output slpc_pkg::alu_req_t                 alu_req,
    input  slpc_pkg::alu_rsp_t                 alu_rsp
);
    import slpc_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_SHIFT = 6'b000100,
        S_PIVOT = 6'b001000,
        S_PAIR  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    action_t                act_reg, act_next;
    logic [VALUE_WIDTH-1:0] value_reg, value_next;
    logic [VALUE_WIDTH-1:0] pivot_reg, pivot_next;
    logic [CNT_W-1:0]       fill_reg, fill_next;
    logic [CNT_W-1:0]       pos_reg, pos_next;
    logic [CNT_W-1:0]       i_reg, i_next;
    logic [CNT_W-1:0]       j_reg, j_next;
    logic [PAIR_W-1:0]      pairs_reg, pairs_next;
    status_t                status_reg, status_next;
    logic                   out_valid_reg, out_valid_next;
    status_t                out_status_reg, out_status_next;
    logic [LEN_W-1:0]       out_len_reg, out_len_next;
    logic [PAIR_W-1:0]      out_pairs_reg, out_pairs_next;

    logic                   in_range;
    logic                   go_on;
    logic [CNT_W-1:0]       i_inc;
    logic [CNT_W-1:0]       j_inc;

    assign in_range = (pos_reg < fill_reg);
    assign i_inc    = i_reg + CNT_W'(1);
    assign j_inc    = j_reg + CNT_W'(1);
    assign go_on    = in_range && ((act_reg == ACT_INSERT) ? (alu_rsp.lt || alu_rsp.eq)
                                                          : alu_rsp.lt);

    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        value_next      = value_reg;
        pivot_next      = pivot_reg;
        fill_next       = fill_reg;
        pos_next        = pos_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        pairs_next      = pairs_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_len_next    = out_len_reg;
        out_pairs_next  = out_pairs_reg;

        ctl           = '0;
        ctl.pos       = pos_reg[IDX_W-1:0];
        ctl.rd_idx    = pos_reg[IDX_W-1:0];
        ctl.wr_value  = value_reg;
        alu_req.x     = rd_data;
        alu_req.y     = '0;
        alu_req.cmp   = SUM_W'(value_reg);

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next    = action;
                    value_next  = value;
                    pos_next    = '0;
                    i_next      = '0;
                    pairs_next  = '0;
                    status_next = ST_OK;
                    unique case (action)
                        ACT_INSERT:
                        begin
                            if (fill_reg == CNT_W'(DEPTH))
                            begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        ACT_DELETE:
                        begin
                            if (fill_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        ACT_COUNT:
                        begin
                            if (fill_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_PIVOT;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (go_on)
                begin
                    pos_next = pos_reg + CNT_W'(1);
                end
                else if (act_reg == ACT_INSERT)
                begin
                    state_next = S_SHIFT;
                end
                else if (in_range && alu_rsp.eq)
                begin
                    state_next = S_SHIFT;
                end
                else
                begin
                    status_next = ST_MISSING;
                    state_next  = S_DONE;
                end
            end
            S_SHIFT:
            begin
                if (act_reg == ACT_INSERT)
                begin
                    ctl.shift_ins = 1'b1;
                    fill_next     = fill_reg + CNT_W'(1);
                end
                else
                begin
                    ctl.shift_del = 1'b1;
                    fill_next     = fill_reg - CNT_W'(1);
                end
                state_next = S_DONE;
            end
            S_PIVOT:
            begin
                ctl.rd_idx = i_reg[IDX_W-1:0];
                if (i_inc >= fill_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    pivot_next = rd_data;
                    j_next     = i_inc;
                    state_next = S_PAIR;
                end
            end
            S_PAIR:
            begin
                ctl.rd_idx = j_reg[IDX_W-1:0];
                alu_req.x  = pivot_reg;
                alu_req.y  = rd_data;
                if (alu_rsp.eq && (32'(pairs_reg) < PAIR_MAX))
                begin
                    pairs_next = pairs_reg + PAIR_W'(1);
                end
                if (j_inc == fill_reg)
                begin
                    i_next     = i_inc;
                    state_next = S_PIVOT;
                end
                else
                begin
                    j_next = j_inc;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_len_next    = sat_len(fill_reg);
                    out_pairs_next  = pairs_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        value_reg      <= value_next;
        pivot_reg      <= pivot_next;
        pos_reg        <= pos_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        pairs_reg      <= pairs_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_len_reg    <= out_len_next;
        out_pairs_reg  <= out_pairs_next;
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign entry_count = out_len_reg;
    assign pair_count  = out_pairs_reg;

endmodule

/* hdl/slpc_checker.sv */
`include "sorted_list_with_pair_sum_count_top_macros.svh"

module slpc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [slpc_pkg::M_TDATA_W-1:0]   m_tdata
);
    import slpc_pkg::*;

    logic [STATUS_W-1:0] st;
    logic [LEN_W-1:0]    len;
    logic [PAIR_W-1:0]   pairs;

    assign st    = m_tdata[STATUS_W-1:0];
    assign len   = m_tdata[LEN_LSB +: LEN_W];
    assign pairs = m_tdata[PAIR_LSB +: PAIR_W];

    `SLPC_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")
    `SLPC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "word dropped")
    `SLPC_ASSERT_NOW(a_pairs_ok, m_tvalid && (pairs != '0), st == ST_OK, "pairs with bad status")
    `SLPC_ASSERT_NOW(a_full_len, m_tvalid && (st == ST_FULL), len == sat_len(CNT_W'(DEPTH)), "full")
    `SLPC_ASSERT_NOW(a_len_range, m_tvalid, 32'(len) <= DEPTH, "length beyond depth")

endmodule

bind sorted_list_with_pair_sum_count_top slpc_checker u_slpc_checker (.*);

/* test/sorted_list_with_pair_sum_count_top_tb.sv */
`timescale 1ns / 100ps

module sorted_list_with_pair_sum_count_top_tb;

    import slpc_pkg::*;

    localparam int RANDOM_WORDS = 1100;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct {
        action_t                act;
        logic [VALUE_WIDTH-1:0] value;
    } store_op_t;

    typedef struct {
        status_t           status;
        logic [LEN_W-1:0]  entry_count;
        logic [PAIR_W-1:0] pair_count;
    } store_result_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [ACTION_W-1:0]  s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    store_op_t            words_to_send[$];
    store_result_t        results_due[$];
    logic [VALUE_WIDTH-1:0] held_values[$];

    logic [VALUE_WIDTH-1:0] model_store[DEPTH];
    int                     model_fill;

    int  error_count = 0;
    int  cycle_count = 0;
    int  send_gap    = 0;
    int  recv_gap    = 0;
    bit  calm        = 1'b0;
    int  pool_base   = 0;
    int  pool_span   = -1;

    sorted_list_with_pair_sum_count_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    function automatic int draw_gap();
        if (calm || $urandom_range(0, 2) == 0)
        begin
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    function automatic store_result_t apply_store_op(store_op_t op);
        store_result_t          res;
        int                     pos;
        int                     pairs;
        logic [VALUE_WIDTH:0]   sum;
        res.status     = ST_OK;
        res.pair_count = '0;
        pairs          = 0;
        case (op.act)
            ACT_INSERT:
            begin
                if (model_fill >= DEPTH)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    pos = 0;
                    while (pos < model_fill && model_store[pos] <= op.value)
                    begin
                        pos++;
                    end
                    for (int k = model_fill; k > pos; k--)
                    begin
                        model_store[k] = model_store[k-1];
                    end
                    model_store[pos] = op.value;
                    model_fill++;
                end
            end
            ACT_DELETE:
            begin
                if (model_fill == 0)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    pos = 0;
                    while (pos < model_fill && model_store[pos] < op.value)
                    begin
                        pos++;
                    end
                    if (pos >= model_fill || model_store[pos] != op.value)
                    begin
                        res.status = ST_MISSING;
                    end
                    else
                    begin
                        for (int k = pos; k + 1 < model_fill; k++)
                        begin
                            model_store[k] = model_store[k+1];
                        end
                        model_fill--;
                    end
                end
            end
            ACT_COUNT:
            begin
                if (model_fill == 0)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    for (int i = 0; i < model_fill; i++)
                    begin
                        for (int j = i + 1; j < model_fill; j++)
                        begin
                            sum = {1'b0, model_store[i]} + {1'b0, model_store[j]};
                            if (sum == {1'b0, op.value} && pairs < PAIR_MAX)
                            begin
                                pairs++;
                            end
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.pair_count  = PAIR_W'(pairs);
        res.entry_count = (model_fill > LEN_MAX) ? LEN_W'(LEN_MAX) : LEN_W'(model_fill);
        return res;
    endfunction

    // sender: one word per handshake, random gap before the next
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= '0;
            send_gap   <= 0;
            model_fill = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                store_op_t op;
                op.act   = action_t'(s_tuser);
                op.value = s_tdata[VALUE_WIDTH-1:0];
                results_due.push_back(apply_store_op(op));
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (words_to_send.size() > 0)
                begin
                    store_op_t nxt;
                    nxt = words_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.act;
                    s_tdata  <= S_TDATA_W'(nxt.value);
                    send_gap <= draw_gap();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: check each word, stall at random afterward
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                store_result_t want;
                int            gap;
                if (results_due.size() == 0)
                begin
                    $error("unexpected result word 0x%0h", m_tdata);
                    error_count++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (m_tdata[STATUS_W-1:0] !== want.status)
                    begin
                        $error("status: expected %0d, got %0d",
                               want.status, m_tdata[STATUS_W-1:0]);
                        error_count++;
                    end
                    if (m_tdata[LEN_LSB +: LEN_W] !== want.entry_count)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, m_tdata[LEN_LSB +: LEN_W]);
                        error_count++;
                    end
                    if (m_tdata[PAIR_LSB +: PAIR_W] !== want.pair_count)
                    begin
                        $error("pair_count: expected %0d, got %0d",
                               want.pair_count, m_tdata[PAIR_LSB +: PAIR_W]);
                        error_count++;
                    end
                end
                gap = draw_gap();
                if (gap > 0)
                begin
                    m_tready <= 1'b0;
                    recv_gap <= gap - 1;
                end
            end
            else if (!m_tready)
            begin
                if (recv_gap > 0)
                begin
                    recv_gap <= recv_gap - 1;
                end
                else
                begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // keeps the multiset of stored values so deletes and targets can hit
    task automatic queue_word(action_t act, logic [VALUE_WIDTH-1:0] value);
        store_op_t op;
        op.act   = act;
        op.value = value;
        while (words_to_send.size() > 2)
        begin
            @(negedge clk);
        end
        words_to_send.push_back(op);
        if (act == ACT_INSERT && held_values.size() < DEPTH)
        begin
            held_values.push_back(value);
        end
        else if (act == ACT_DELETE)
        begin
            foreach (held_values[k])
            begin
                if (held_values[k] == value)
                begin
                    held_values.delete(k);
                    break;
                end
            end
        end
    endtask

    task automatic wait_drained();
        while (words_to_send.size() > 0 || s_tvalid || results_due.size() > 0)
        begin
            @(negedge clk);
        end
    endtask

    function automatic logic [VALUE_WIDTH-1:0] pick_value();
        if (pool_span < 0)
        begin
            return VALUE_WIDTH'($urandom_range(0, 65535));
        end
        return VALUE_WIDTH'(pool_base + $urandom_range(0, pool_span));
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] pick_target();
        int i;
        int j;
        int sum;
        if (held_values.size() >= 2 && $urandom_range(0, 1) == 0)
        begin
            i = $urandom_range(0, held_values.size() - 1);
            j = $urandom_range(0, held_values.size() - 2);
            if (j >= i)
            begin
                j++;
            end
            sum = int'(held_values[i]) + int'(held_values[j]);
            if (sum <= 65535)
            begin
                return VALUE_WIDTH'(sum);
            end
        end
        if ($urandom_range(0, 1) == 0)
        begin
            return pick_value() + pick_value();
        end
        return VALUE_WIDTH'($urandom_range(0, 65535));
    endfunction

    initial
    begin
        int sent;
        int phase_len;
        int ins_pct;
        int del_pct;
        int roll;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty store, single entry, pairs with zero, extremes, unused action
        queue_word(ACT_COUNT, 16'h0000);
        queue_word(ACT_DELETE, 16'h0000);
        queue_word(ACT_NONE, 16'hffff);
        queue_word(ACT_INSERT, 16'h0000);
        queue_word(ACT_COUNT, 16'h0000);
        queue_word(ACT_DELETE, 16'h0001);
        queue_word(ACT_DELETE, 16'h0000);
        queue_word(ACT_INSERT, 16'hffff);
        queue_word(ACT_INSERT, 16'h0000);
        queue_word(ACT_COUNT, 16'hffff);
        queue_word(ACT_INSERT, 16'hffff);
        queue_word(ACT_COUNT, 16'hffff);
        queue_word(ACT_DELETE, 16'hffff);
        queue_word(ACT_DELETE, 16'h8000);
        queue_word(ACT_INSERT, 16'h5555);
        queue_word(ACT_INSERT, 16'haaaa);
        queue_word(ACT_COUNT, 16'hffff);
        queue_word(ACT_NONE, 16'h1234);
        queue_word(ACT_DELETE, 16'h0000);
        queue_word(ACT_DELETE, 16'hffff);
        queue_word(ACT_DELETE, 16'haaaa);
        queue_word(ACT_DELETE, 16'h5555);
        queue_word(ACT_COUNT, 16'h0000);
        wait_drained();

        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                wait_drained();
            end
            calm      = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(20, 80);
            case ($urandom_range(0, 2))
                0:       pool_base = 0;
                1:       pool_base = $urandom_range(0, 255);
                default: pool_base = $urandom_range(0, 65535);
            endcase
            case ($urandom_range(0, 5))
                0:       pool_span = 0;
                1:       pool_span = 1;
                2:       pool_span = 3;
                3:       pool_span = 7;
                4:       pool_span = 15;
                default: pool_span = -1;
            endcase
            case ($urandom_range(0, 2))
                0:
                begin
                    ins_pct = 60;
                    del_pct = 15;
                end
                1:
                begin
                    ins_pct = 15;
                    del_pct = 60;
                end
                default:
                begin
                    ins_pct = 35;
                    del_pct = 30;
                end
            endcase
            repeat (phase_len)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 5)
                begin
                    queue_word(ACT_NONE, VALUE_WIDTH'($urandom_range(0, 65535)));
                end
                else if (roll < 5 + ins_pct)
                begin
                    queue_word(ACT_INSERT, pick_value());
                end
                else if (roll < 5 + ins_pct + del_pct)
                begin
                    if (held_values.size() > 0 && $urandom_range(0, 9) < 7)
                    begin
                        queue_word(ACT_DELETE,
                                   held_values[$urandom_range(0, held_values.size() - 1)]);
                    end
                    else
                    begin
                        queue_word(ACT_DELETE, pick_value());
                    end
                end
                else
                begin
                    queue_word(ACT_COUNT, pick_target());
                end
                sent++;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* sorted_list_with_pair_sum_count_top.f */
+incdir+hdl
hdl/slpc_pkg.sv
hdl/slpc_alu.sv
hdl/slpc_store.sv
hdl/slpc_ctrl.sv
hdl/sorted_list_with_pair_sum_count_top.sv
hdl/slpc_checker.sv
test/sorted_list_with_pair_sum_count_top_tb.sv
